FILE: src/bps_pkg.sv
// shared types and constants for the byte pattern search unit
`timescale 1ns / 1ps

package bps_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int BUFFER_MAX_DEF  = 65536;
    localparam int LEN_CAP_HW      = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_W      = 5;
    localparam int OFFSET_W   = 32;
    localparam int SLOT_W     = 16;
    localparam int COUNT_W    = 17;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HI = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SLOT = 3'd4;

    localparam logic KIND_MATCH = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic                       result_kind;
        logic signed [OFFSET_W-1:0] found_offset;
        logic [COUNT_W-1:0]         slot_number;
        logic [COUNT_W-1:0]         match_count;
        logic                       last_result;
    } t_result;

    typedef struct packed {
        logic [1:0] num;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

FILE: src/bps_cell.sv
// one window cell: holds a buffer byte and compares the byte handed in against its pattern byte
`timescale 1ns / 1ps

module bps_cell (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  logic [7:0] i_byte_in,
    input  logic [7:0] i_pat_byte,
    input  logic       i_enable,
    output logic [7:0] o_byte,
    output logic       o_hit
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else if (i_shift) begin
            r_byte <= i_byte_in;
        end
    end

    assign o_byte = r_byte;
    assign o_hit  = !i_enable || (i_byte_in == i_pat_byte);

endmodule

FILE: src/bps_result_fifo.sv
// small result queue: takes up to two results per cycle, hands out one per transfer
`timescale 1ns / 1ps

module bps_result_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bps_pkg::t_push   i_push,
    output logic             o_room2,
    output logic             o_valid,
    input  logic             i_ready,
    output bps_pkg::t_result o_result
);

    import bps_pkg::*;

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_cnt;
    logic [FIFO_CNT_W-1:0] n_cnt;
    logic                  w_pop;

    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_cnt != '0);
    assign o_room2 = (r_cnt <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign o_result = r_mem[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt + FIFO_CNT_W'(i_push.num) - FIFO_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.num == 2'd2) begin
            r_mem[r_wr_ptr + FIFO_PTR_W'(1)] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(i_push.num);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: src/byte_pattern_search_unit.sv
// top level of the byte pattern search unit
//
// usage: buffer bytes enter on the input channel (valid/ready), one per transfer,
// with last_byte set on the final byte of a buffer. results leave on the output
// channel: a match result for each leftmost non-overlapping occurrence of the
// configured pattern, and a count result after the final byte of each buffer.
// throughput: one byte per cycle while the input is ready, set by the row of
// compare cells, which shift the window and check all pattern bytes in the
// cycle a byte is taken. each result enters the queue on the edge that takes
// the byte ending it; a final byte completing a match queues two, match first.
// results wait in a four-entry queue; the input ready drops while it holds more
// than two, so a stalled receiver holds back the byte stream without loss.
// configuration is a plain write port (enable, index, data), used while idle.
// reset (synchronous, active low) restores register defaults, empties the
// queue and clears the per-buffer position, count and window.
`timescale 1ns / 1ps

module byte_pattern_search_unit #(
    parameter int PATTERN_MAX = bps_pkg::PATTERN_MAX_DEF,
    parameter int BUFFER_MAX  = bps_pkg::BUFFER_MAX_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  bps_pkg::t_item               i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output bps_pkg::t_result             o_out_result
);

    import bps_pkg::*;

    localparam int CAP   = (PATTERN_MAX < LEN_CAP_HW) ? PATTERN_MAX : LEN_CAP_HW;
    localparam int POS_W = $clog2(BUFFER_MAX + 1);

    logic [63:0]         r_pat_lo;
    logic [63:0]         r_pat_hi;
    logic [LEN_W-1:0]    r_len;
    logic [OFFSET_W-1:0] r_base;
    logic [SLOT_W-1:0]   r_first_slot;

    logic [POS_W-1:0]    r_pos;
    logic [POS_W-1:0]    r_next;
    logic [COUNT_W-1:0]  r_cnt;
    logic [COUNT_W-1:0]  n_cnt;

    logic [LEN_W-1:0]    w_len;
    logic [127:0]        w_pat_all;
    logic [7:0]          w_pat_sel [CAP];
    logic [CAP-1:0]      w_en;
    logic [7:0]          w_byte [CAP];
    logic [CAP-1:0]      w_hit;

    logic                w_accept;
    logic                w_searching;
    logic [POS_W:0]      w_pos1;
    logic                w_full;
    logic [POS_W-1:0]    w_start;
    logic                w_match;
    logic                w_room2;
    t_result             w_mres;
    t_result             w_cres;
    t_push               w_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo     <= '0;
            r_pat_hi     <= '0;
            r_len        <= LEN_W'(1);
            r_base       <= '0;
            r_first_slot <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PATTERN_LO:  r_pat_lo     <= i_cfg_data;
                CFG_PATTERN_HI:  r_pat_hi     <= i_cfg_data;
                CFG_PATTERN_LEN: r_len        <= i_cfg_data[LEN_W-1:0];
                CFG_BASE_OFFSET: r_base       <= i_cfg_data[OFFSET_W-1:0];
                CFG_FIRST_SLOT:  r_first_slot <= i_cfg_data[SLOT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_len == '0) begin
            w_len = LEN_W'(1);
        end else if (r_len > LEN_W'(CAP)) begin
            w_len = LEN_W'(CAP);
        end else begin
            w_len = r_len;
        end
    end

    assign w_pat_all = {r_pat_hi, r_pat_lo};

    always_comb begin
        for (int k = 0; k < CAP; k++) begin
            w_en[k]      = LEN_W'(k) < w_len;
            w_pat_sel[k] = w_pat_all[8 * (4'(w_len - LEN_W'(k) - LEN_W'(1))) +: 8];
        end
    end

    assign w_accept = i_in_valid && o_in_ready;

    genvar g;
    generate
        for (g = 0; g < CAP; g++) begin : g_cell
            bps_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_shift    (w_accept),
                .i_byte_in  ((g == 0) ? i_in_item.data_byte : w_byte[(g == 0) ? 0 : g - 1]),
                .i_pat_byte (w_pat_sel[g]),
                .i_enable   (w_en[g]),
                .o_byte     (w_byte[g]),
                .o_hit      (w_hit[g])
            );
        end
    endgenerate

    assign w_searching = r_pos < POS_W'(BUFFER_MAX);
    assign w_pos1      = {1'b0, r_pos} + (POS_W + 1)'(1);
    assign w_full      = w_pos1 >= (POS_W + 1)'(w_len);
    assign w_start     = POS_W'(w_pos1 - (POS_W + 1)'(w_len));
    assign w_match     = w_accept && w_searching && w_full && (w_start >= r_next) && (&w_hit);

    always_comb begin
        n_cnt = r_cnt;
        if (w_match && (r_cnt != COUNT_MAX)) begin
            n_cnt = r_cnt + COUNT_W'(1);
        end
    end

    always_comb begin
        w_mres              = '0;
        w_mres.result_kind  = KIND_MATCH;
        w_mres.found_offset = {{(OFFSET_W - POS_W){1'b0}}, w_start} + r_base;
        w_mres.slot_number  = {1'b0, r_first_slot} + r_cnt;
        w_cres              = '0;
        w_cres.result_kind  = KIND_COUNT;
        w_cres.match_count  = n_cnt;
        w_cres.last_result  = 1'b1;
    end

    always_comb begin
        w_push.num    = 2'(w_match) + 2'(w_accept && i_in_item.last_byte);
        w_push.first  = w_match ? w_mres : w_cres;
        w_push.second = w_cres;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_next <= '0;
            r_cnt  <= '0;
        end else if (w_accept) begin
            if (i_in_item.last_byte) begin
                r_pos  <= '0;
                r_next <= '0;
                r_cnt  <= '0;
            end else begin
                if (w_searching) begin
                    r_pos <= POS_W'(w_pos1);
                end
                if (w_match) begin
                    r_next <= POS_W'(w_pos1);
                end
                r_cnt <= n_cnt;
            end
        end
    end

    bps_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .o_room2  (w_room2),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (o_out_result)
    );

    assign o_in_ready = w_room2;

endmodule

FILE: src/bps_checker.sv
// port-level checks for the byte pattern search unit, bound to the top level
`timescale 1ns / 1ps

module bps_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input bps_pkg::t_result o_out_result
);

    import bps_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_result))
        else $error("result changed or dropped while stalled");

    a_count_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_result.result_kind == KIND_COUNT) |->
        o_out_result.last_result && (o_out_result.found_offset == '0) &&
        (o_out_result.slot_number == '0))
        else $error("malformed count result");

    a_match_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_result.result_kind == KIND_MATCH) |->
        !o_out_result.last_result && (o_out_result.match_count == '0))
        else $error("malformed match result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result queue");

endmodule

bind byte_pattern_search_unit bps_checker u_bps_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_result (o_out_result)
);
